// ----- rtl/core/wsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wsp_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int SizeW    = 14;
  localparam int ClipW    = 58;
  localparam int ScaleW   = SizeW + 15;
  localparam int HalfW    = ClipW / 2;
  localparam int ProdW    = ClipW + ScaleW;
  localparam int QuotW    = 41;
  localparam int RemW     = ClipW;
  localparam int DivSteps = QuotW;
  localparam int PixW     = 44;

  localparam logic [CfgIdxW-1:0] REG_ROW0_01 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW0_23 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW1_01 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROW1_23 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW3_01 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROW3_23 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_WIDTH   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT  = 3'd7;

  localparam logic [SizeW-1:0] WIDTH_RESET  = 14'd1920;
  localparam logic [SizeW-1:0] HEIGHT_RESET = 14'd1080;

  // 0.001 in Q.24, rounded up.
  localparam logic signed [ClipW-1:0] VIS_MIN = 58'sd16778;
  localparam logic [QuotW-1:0] OFFSET_CAP = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } result_t;

  typedef struct packed {
    logic [5:0][CfgDataW-1:0] coef_reg;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } cfg_t;

  typedef struct packed {
    logic             visible;
    logic             neg_x;
    logic [ClipW-1:0] mag_x;
    logic             neg_y;
    logic [ClipW-1:0] mag_y;
    logic [ClipW-1:0] w;
  } front_item_t;

  typedef struct packed {
    logic             visible;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [ClipW-1:0] w;
    logic [RemW-1:0]  rem_x;
    logic [QuotW-1:0] sh_x;
    logic [RemW-1:0]  rem_y;
    logic [QuotW-1:0] sh_y;
  } div_t;

  // One restoring step: bring down the next dividend bit, shift in a quotient bit.
  function automatic div_t div_step(input div_t d);
    div_t             n;
    logic [RemW:0]    tx;
    logic [RemW:0]    ty;
    n  = d;
    tx = {d.rem_x, d.sh_x[QuotW-1]};
    ty = {d.rem_y, d.sh_y[QuotW-1]};
    if (tx >= {1'b0, d.w}) begin
      tx = tx - {1'b0, d.w};
      n.sh_x = {d.sh_x[QuotW-2:0], 1'b1};
    end else begin
      n.sh_x = {d.sh_x[QuotW-2:0], 1'b0};
    end
    if (ty >= {1'b0, d.w}) begin
      ty = ty - {1'b0, d.w};
      n.sh_y = {d.sh_y[QuotW-2:0], 1'b1};
    end else begin
      n.sh_y = {d.sh_y[QuotW-2:0], 1'b0};
    end
    n.rem_x = tx[RemW-1:0];
    n.rem_y = ty[RemW-1:0];
    return n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PixW-1:0] v);
    if (v > $signed(PixW'(32'h7FFF_FFFF))) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -$signed(PixW'(33'h0_8000_0000))) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/world_to_screen_projection_core.sv -----
// Throughput: one item per cycle; the front stalls only when the middle queue is full,
// the back only when the two-entry result queue is full.
// The back's 41-step pipelined restoring divider sets the latency.
// Reset (synchronous, active high) empties all queues and restores the registers:
// matrix coefficients zero, width 1920, height 1080.
`timescale 1ns / 1ps
`default_nettype none
module world_to_screen_projection_core import wsp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  input  wire logic                push,
  input  wire point_t              point,
  output logic                     full,
  output logic                     empty,
  output result_t                  result,
  input  wire logic                pop
);

  cfg_t cfg;
  front_item_t f_item, q_item;
  logic f_valid, f_ready, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_reg <= '0;
      cfg.width    <= WIDTH_RESET;
      cfg.height   <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_01: cfg.coef_reg[0] <= cfg_data;
        REG_ROW0_23: cfg.coef_reg[1] <= cfg_data;
        REG_ROW1_01: cfg.coef_reg[2] <= cfg_data;
        REG_ROW1_23: cfg.coef_reg[3] <= cfg_data;
        REG_ROW3_01: cfg.coef_reg[4] <= cfg_data;
        REG_ROW3_23: cfg.coef_reg[5] <= cfg_data;
        REG_WIDTH:   cfg.width       <= cfg_data[SizeW-1:0];
        REG_HEIGHT:  cfg.height      <= cfg_data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  wsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .point      (point),
    .full       (full),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  wsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_item  (f_item),
    .wr_en    (f_valid),
    .wr_ready (f_ready),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_en    (q_pop)
  );

  wsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (q_item),
    .item_valid (q_valid),
    .item_pop   (q_pop),
    .empty      (empty),
    .result     (result),
    .pop        (pop)
  );

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.visible |-> result.screen_x == 32'sd0 && result.screen_y == 32'sd0)
    else $error("hidden point with nonzero coordinates");

  a_zero_width: assert property (@(posedge clk) disable iff (rst)
    !empty && cfg.width == '0 |-> result.screen_x == 32'sd0)
    else $error("zero width gave nonzero x");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !full && empty)
    else $error("queues not clear after reset");

endmodule
`default_nettype wire

// ----- rtl/core/wsp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wsp_front import wsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        push,
  input  wire point_t      point,
  output logic             full,
  output front_item_t      item,
  output logic             item_valid,
  input  wire logic        item_ready
);

  logic v1, v2, v3;
  logic adv;
  logic signed [55:0] term [3][3];
  logic signed [39:0] konst [3];
  logic signed [55:0] term_c [3][3];
  logic signed [39:0] konst_c [3];
  logic signed [ClipW-1:0] clip [3];
  front_item_t out_q;

  assign adv  = !v3 || item_ready;
  assign full = !adv;

  always_comb begin
    logic signed [63:0] p;
    logic signed [31:0] c;
    for (int r = 0; r < 3; r++) begin
      c = cfg.coef_reg[2*r][31:0];
      p = c * point.point_x;
      term_c[r][0] = p[63:8];
      c = cfg.coef_reg[2*r][63:32];
      p = c * point.point_y;
      term_c[r][1] = p[63:8];
      c = cfg.coef_reg[2*r+1][31:0];
      p = c * point.point_z;
      term_c[r][2] = p[63:8];
      konst_c[r] = {cfg.coef_reg[2*r+1][63:32], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      term  <= term_c;
      konst <= konst_c;
      for (int r = 0; r < 3; r++) begin
        clip[r] <= ClipW'(term[r][0]) + ClipW'(term[r][1]) + ClipW'(term[r][2])
                   + ClipW'(konst[r]);
      end
      out_q.visible <= clip[2] >= VIS_MIN;
      out_q.neg_x   <= clip[0][ClipW-1];
      out_q.mag_x   <= clip[0][ClipW-1] ? ClipW'(-clip[0]) : ClipW'(clip[0]);
      out_q.neg_y   <= clip[1][ClipW-1];
      out_q.mag_y   <= clip[1][ClipW-1] ? ClipW'(-clip[1]) : ClipW'(clip[1]);
      out_q.w       <= ClipW'(clip[2]);
    end
  end

  assign item       = out_q;
  assign item_valid = v3;

endmodule
`default_nettype wire

// ----- rtl/core/wsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wsp_queue import wsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire front_item_t wr_item,
  input  wire logic        wr_en,
  output logic             wr_ready,
  output front_item_t      rd_item,
  output logic             rd_valid,
  input  wire logic        rd_en
);

  front_item_t mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule
`default_nettype wire

// ----- rtl/core/wsp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wsp_back import wsp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire front_item_t item,
  input  wire logic        item_valid,
  output logic             item_pop,
  output logic             empty,
  output result_t          result,
  input  wire logic        pop
);

  logic [ScaleW-1:0] scale_w, scale_h;
  logic adv;
  logic b1v, b2v;
  logic dvv [DivSteps+1];
  div_t dv [DivSteps+1];

  // Stage 1: partial products of the magnitudes with the half-size scales.
  logic [2*HalfW-1:0] lo_x, hi_x, lo_y, hi_y;
  logic b1_vis, b1_nx, b1_ny;
  logic [ClipW-1:0] b1_w;
  // Stage 2: full products.
  logic [ProdW-1:0] prod_x, prod_y;
  logic b2_vis, b2_nx, b2_ny;
  logic [ClipW-1:0] b2_w;

  div_t d0;
  result_t res_c;
  result_t omem [2];
  logic optr_w, optr_r;
  logic [1:0] ocount;
  logic do_wr, do_rd;

  assign scale_w  = {cfg.width, 15'd0};
  assign scale_h  = {cfg.height, 15'd0};
  assign adv      = !dvv[DivSteps] || ocount != 2'd2;
  assign item_pop = adv && item_valid;

  always_comb begin
    d0 = '0;
    d0.visible = b2_vis;
    d0.neg_x   = b2_nx;
    d0.neg_y   = b2_ny;
    d0.w       = b2_w;
    d0.ovf_x   = ClipW'(prod_x[ProdW-1:QuotW]) >= b2_w;
    d0.ovf_y   = ClipW'(prod_y[ProdW-1:QuotW]) >= b2_w;
    // An overflowed lane is capped anyway, so its remainder is cleared to keep it below w.
    d0.rem_x   = d0.ovf_x ? '0 : RemW'(prod_x[ProdW-1:QuotW]);
    d0.rem_y   = d0.ovf_y ? '0 : RemW'(prod_y[ProdW-1:QuotW]);
    d0.sh_x    = prod_x[QuotW-1:0];
    d0.sh_y    = prod_y[QuotW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1v <= 1'b0;
      b2v <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) dvv[k] <= 1'b0;
    end else if (adv) begin
      b1v    <= item_valid;
      b2v    <= b1v;
      dvv[0] <= b2v;
      for (int k = 1; k <= DivSteps; k++) dvv[k] <= dvv[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_x   <= item.mag_x[HalfW-1:0] * scale_w;
      hi_x   <= item.mag_x[ClipW-1:HalfW] * scale_w;
      lo_y   <= item.mag_y[HalfW-1:0] * scale_h;
      hi_y   <= item.mag_y[ClipW-1:HalfW] * scale_h;
      b1_vis <= item.visible;
      b1_nx  <= item.neg_x;
      b1_ny  <= item.neg_y;
      b1_w   <= item.w;
      prod_x <= ProdW'(lo_x) + (ProdW'(hi_x) << HalfW);
      prod_y <= ProdW'(lo_y) + (ProdW'(hi_y) << HalfW);
      b2_vis <= b1_vis;
      b2_nx  <= b1_nx;
      b2_ny  <= b1_ny;
      b2_w   <= b1_w;
      dv[0]  <= d0;
      for (int k = 1; k <= DivSteps; k++) dv[k] <= div_step(dv[k-1]);
    end
  end

  always_comb begin
    logic [QuotW-1:0] qx, qy;
    logic signed [PixW-1:0] sx, sy;
    div_t d;
    d  = dv[DivSteps];
    qx = (d.ovf_x || d.sh_x > OFFSET_CAP) ? OFFSET_CAP : d.sh_x;
    qy = (d.ovf_y || d.sh_y > OFFSET_CAP) ? OFFSET_CAP : d.sh_y;
    sx = $signed(PixW'(scale_w)) + (d.neg_x ? -$signed(PixW'(qx)) : $signed(PixW'(qx)));
    sy = $signed(PixW'(scale_h)) + (d.neg_y ? $signed(PixW'(qy)) : -$signed(PixW'(qy)));
    res_c.visible  = d.visible;
    res_c.screen_x = d.visible ? sat32(sx) : 32'sd0;
    res_c.screen_y = d.visible ? sat32(sy) : 32'sd0;
  end

  assign do_wr  = dvv[DivSteps] && adv;
  assign do_rd  = pop && !empty;
  assign empty  = ocount == 2'd0;
  assign result = omem[optr_r];

  always_ff @(posedge clk) begin
    if (rst) begin
      optr_w <= 1'b0;
      optr_r <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (do_wr) optr_w <= !optr_w;
      if (do_rd) optr_r <= !optr_r;
      ocount <= ocount + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) omem[optr_w] <= res_c;
  end

endmodule
`default_nettype wire
